// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the dirty rectangle block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/drtc_pkg.sv =====
// Shared types and constants of the dirty rectangle tracker.
package drtc_pkg;

  // Coordinate width of boxes, view bounds and result rectangles.
  localparam int unsigned CoordW = 15;
  // Width of the screen size registers and of the console row count.
  localparam int unsigned CfgW = 13;
  // Width of the view size register.
  localparam int unsigned ViewW = 7;
  // Most rectangles that one frame end can produce.
  localparam int unsigned MaxRects = 4;
  localparam int unsigned SelW = $clog2(MaxRects);
  // Default number of earlier frames kept in the history.
  localparam int unsigned HISTORY_FRAMES_DEF = 2;

  // Floor division by 100 of a 20-bit product: multiply and shift.
  localparam int unsigned ProdW = CfgW + ViewW;
  localparam int unsigned DivMulW = 21;
  localparam int unsigned DivShift = 27;
  localparam logic [DivMulW-1:0] DivMul = 21'd1342178;

  // Clamp limits of the view size in percent.
  localparam logic [ViewW-1:0] ViewMin = 7'd40;
  localparam logic [ViewW-1:0] ViewMax = 7'd100;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SCREEN_WIDTH  = 2'd0,
    REG_SCREEN_HEIGHT = 2'd1,
    REG_VIEW_SIZE     = 2'd2,
    REG_DRAW_ALL      = 2'd3
  } reg_idx_e;

  // Input commands.
  typedef enum logic [1:0] {
    CMD_ADD_POINT   = 2'd0,
    CMD_MARK_SCREEN = 2'd1,
    CMD_FRAME_END   = 2'd2
  } command_e;

  // Bounding box, inclusive bounds.
  typedef struct packed {
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
    logic signed [CoordW-1:0] x2;
    logic signed [CoordW-1:0] y2;
  } box_t;

  // Bounds of the centered view, inclusive.
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic signed [CoordW-1:0] right;
    logic signed [CoordW-1:0] bottom;
  } view_t;

  // One rectangle to clear.
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [CoordW-1:0]        w;
    logic [CoordW-1:0]        h;
  } rect_t;

  // All results of one frame end: pending mask, empty flag and rectangles.
  typedef struct packed {
    logic [MaxRects-1:0] pend;
    logic                empty;
    rect_t [MaxRects-1:0] rects;
  } strips_t;

  localparam box_t BoxZero = '0;
  localparam box_t BoxReset = '{x1: 15'sd9999, y1: 15'sd9999,
                                x2: -15'sd9999, y2: -15'sd9999};

endpackage

// ===== rtl/core/drtc_strip_cut.sv =====
// Cuts the dirty union box into up to four strips around the view.
module drtc_strip_cut
  import drtc_pkg::*;
(
  input  box_t    box_i,
  input  view_t   view_i,
  input  logic    full_i,
  output strips_t strips_o
);

  logic                     ok;
  logic                     s0, s1, s2, s3;
  logic signed [CoordW-1:0] top_m1, bot_p1, left_m1, right_p1;
  logic signed [CoordW-1:0] lim0, lim1, lim2, lim3;
  logic signed [CoordW-1:0] ya, yb, xa;

  always_comb begin
    ok       = !full_i && (box_i.y2 > box_i.y1);
    top_m1   = view_i.top - 15'sd1;
    bot_p1   = view_i.bottom + 15'sd1;
    left_m1  = view_i.left - 15'sd1;
    right_p1 = view_i.right + 15'sd1;

    // Strip above the view.
    s0   = ok && (box_i.y1 < view_i.top);
    lim0 = (box_i.y2 < top_m1) ? box_i.y2 : top_m1;
    ya   = s0 ? view_i.top : box_i.y1;

    // Strip below the view, starting at the already trimmed top.
    s1   = ok && (box_i.y2 > view_i.bottom);
    lim1 = (ya > bot_p1) ? ya : bot_p1;
    yb   = s1 ? view_i.bottom : box_i.y2;

    // Strip left of the view, between the trimmed top and bottom.
    s2   = ok && (box_i.x1 < view_i.left);
    lim2 = (box_i.x2 < left_m1) ? box_i.x2 : left_m1;
    xa   = s2 ? view_i.left : box_i.x1;

    // Strip right of the view.
    s3   = ok && (box_i.x2 > view_i.right);
    lim3 = (xa > right_p1) ? xa : right_p1;

    strips_o = '0;
    strips_o.rects[0].x = box_i.x1;
    strips_o.rects[0].y = box_i.y1;
    strips_o.rects[0].w = $unsigned(box_i.x2 - box_i.x1 + 15'sd1);
    strips_o.rects[0].h = $unsigned(lim0 - box_i.y1 + 15'sd1);

    strips_o.rects[1].x = box_i.x1;
    strips_o.rects[1].y = lim1;
    strips_o.rects[1].w = $unsigned(box_i.x2 - box_i.x1 + 15'sd1);
    strips_o.rects[1].h = $unsigned(box_i.y2 - lim1 + 15'sd1);

    strips_o.rects[2].x = box_i.x1;
    strips_o.rects[2].y = ya;
    strips_o.rects[2].w = $unsigned(lim2 - box_i.x1 + 15'sd1);
    strips_o.rects[2].h = $unsigned(yb - ya + 15'sd1);

    strips_o.rects[3].x = lim3;
    strips_o.rects[3].y = ya;
    strips_o.rects[3].w = $unsigned(box_i.x2 - lim3 + 15'sd1);
    strips_o.rects[3].h = $unsigned(yb - ya + 15'sd1);

    strips_o.pend = {s3, s2, s1, s0};

    // Nothing to clear: a single empty word with zero fields.
    if (strips_o.pend == '0) begin
      strips_o.rects = '0;
      strips_o.empty = 1'b1;
      strips_o.pend  = MaxRects'(1);
    end
  end

endmodule

// ===== rtl/core/dirty_rect_tile_clear.sv =====
// Top level of the dirty rectangle tracker with background strip output.
// Add-point and mark-screen words update the current dirty box in the cycle
// they are taken and produce no output. A frame-end word passes four register
// stages (box union and view products, divide by 100, view bounds, strip cut);
// its output words are presented from the last of these, the output bundle.
// It yields one to four words, one per cycle while the sink is ready, the
// last flagged by tlast. The input accepts one word per cycle; it stalls only
// when all three frame-end stages are occupied behind an output bundle that
// is still draining.
// Configuration writes take effect at the next clock edge and must only be
// issued while no frame end is in flight.
`include "assert_macros.svh"

module dirty_rect_tile_clear
  import drtc_pkg::*;
#(
  parameter int unsigned HistoryFrames = HISTORY_FRAMES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  // Command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // point_x[13:0], point_y[27:14], console_rows[40:28], cinematic_active[41]
  input  logic [47:0] s_axis_tdata,
  // command[1:0]
  input  logic [1:0]  s_axis_tuser,
  // Rectangle stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // rect_x[14:0], rect_y[29:15], rect_w[44:30], rect_h[59:45]
  output logic [63:0] m_axis_tdata,
  // empty_res[0]
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  // Widen the box so that it holds the point.
  function automatic box_t grow(box_t b, logic signed [CoordW-1:0] x,
                                logic signed [CoordW-1:0] y);
    box_t r;
    r = b;
    if (x < b.x1) r.x1 = x;
    if (x > b.x2) r.x2 = x;
    if (y < b.y1) r.y1 = y;
    if (y > b.y2) r.y2 = y;
    return r;
  endfunction

  // Configuration registers
  logic [CfgW-1:0]  sw_q, sh_q;
  logic [ViewW-1:0] vsize_q;
  logic             draw_all_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q       <= 13'd800;
      sh_q       <= 13'd600;
      vsize_q    <= 7'd100;
      draw_all_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_SCREEN_WIDTH:  sw_q       <= cfg_data_i[CfgW-1:0];
        REG_SCREEN_HEIGHT: sh_q       <= cfg_data_i[CfgW-1:0];
        REG_VIEW_SIZE:     vsize_q    <= cfg_data_i[ViewW-1:0];
        REG_DRAW_ALL:      draw_all_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input word fields
  command_e                 in_cmd;
  logic signed [CoordW-1:0] in_x, in_y;
  logic [CfgW-1:0]          in_con;
  logic                     in_cine;

  assign in_cmd  = command_e'(s_axis_tuser);
  assign in_x    = $signed({s_axis_tdata[13], s_axis_tdata[13:0]});
  assign in_y    = $signed({s_axis_tdata[27], s_axis_tdata[27:14]});
  assign in_con  = s_axis_tdata[40:28];
  assign in_cine = s_axis_tdata[41];

  // Pipeline control
  logic v1_q, v2_q, v3_q;
  logic [MaxRects-1:0] pend_q, pend_clr;
  logic fire, fe_fire, b_free, ld_b, adv3, adv2, rdy2, rdy3, out_fire;

  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign pend_clr = pend_q & (pend_q - MaxRects'(1));
  assign b_free   = (pend_q == '0) || (m_axis_tready && (pend_clr == '0));
  assign ld_b     = v3_q && b_free;
  assign rdy3     = !v3_q || ld_b;
  assign adv3     = v2_q && rdy3;
  assign rdy2     = !v2_q || adv3;
  assign adv2     = v1_q && rdy2;
  assign s_axis_tready = !v1_q || rdy2;
  assign fire     = s_axis_tvalid && s_axis_tready;
  assign fe_fire  = fire && (in_cmd == CMD_FRAME_END);

  // Box state, history and frame-end decision
  box_t             cur_q, cur_d;
  box_t             old_q [HistoryFrames];
  box_t             old_d [HistoryFrames];
  box_t             screen_box, marked_box, union_box;
  logic signed [CoordW-1:0] sw_m1, sh_m1;
  logic [ViewW-1:0] size;
  logic             fe_full;

  always_comb begin
    sw_m1      = $signed({2'b00, sw_q}) - 15'sd1;
    sh_m1      = $signed({2'b00, sh_q}) - 15'sd1;
    screen_box = grow(grow(cur_q, 15'sd0, 15'sd0), sw_m1, sh_m1);
    marked_box = draw_all_q ? screen_box : cur_q;

    if (vsize_q < ViewMin) begin
      size = ViewMin;
    end else if (vsize_q > ViewMax) begin
      size = ViewMax;
    end else begin
      size = vsize_q;
    end
    fe_full = (in_con >= sh_q) || (size == ViewMax) || in_cine;

    // Union with all earlier frames.
    union_box = marked_box;
    for (int i = 0; i < HistoryFrames; i++) begin
      if (old_q[i].x1 < union_box.x1) union_box.x1 = old_q[i].x1;
      if (old_q[i].x2 > union_box.x2) union_box.x2 = old_q[i].x2;
      if (old_q[i].y1 < union_box.y1) union_box.y1 = old_q[i].y1;
      if (old_q[i].y2 > union_box.y2) union_box.y2 = old_q[i].y2;
    end

    cur_d = cur_q;
    old_d = old_q;
    if (fire) begin
      unique case (in_cmd)
        CMD_ADD_POINT:   cur_d = grow(cur_q, in_x, in_y);
        CMD_MARK_SCREEN: cur_d = screen_box;
        CMD_FRAME_END: begin
          if (fe_full) begin
            cur_d = marked_box;
          end else begin
            for (int i = 1; i < HistoryFrames; i++) begin
              old_d[i] = old_q[i-1];
            end
            old_d[0] = marked_box;
            cur_d    = BoxReset;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= BoxZero;
      for (int i = 0; i < HistoryFrames; i++) begin
        old_q[i] <= BoxZero;
      end
    end else begin
      cur_q <= cur_d;
      old_q <= old_d;
    end
  end

  // Stage 1: union box, console rows and view size products
  box_t             s1_box_q;
  logic [CfgW-1:0]  s1_con_q;
  logic             s1_full_q;
  logic [ProdW-1:0] s1_pw_q, s1_ph_q;

  always_ff @(posedge clk_i) begin
    if (fe_fire) begin
      s1_box_q  <= union_box;
      s1_con_q  <= in_con;
      s1_full_q <= fe_full;
      s1_pw_q   <= {{ViewW{1'b0}}, sw_q} * {{CfgW{1'b0}}, size};
      s1_ph_q   <= {{ViewW{1'b0}}, sh_q} * {{CfgW{1'b0}}, size};
    end
  end

  // Stage 2: console clip of the top edge and division by 100
  localparam int unsigned MulW = ProdW + DivMulW;
  box_t                  clip_box, s2_box_q;
  logic                  s2_full_q;
  logic [MulW-1:0]       mul_w, mul_h;
  logic [CfgW-1:0]       s2_qw_q, s2_qh_q;
  logic signed [CoordW-1:0] con_s;

  always_comb begin
    con_s    = $signed({2'b00, s1_con_q});
    clip_box = s1_box_q;
    if (con_s >= s1_box_q.y1) clip_box.y1 = con_s;
    mul_w = {{DivMulW{1'b0}}, s1_pw_q} * {{ProdW{1'b0}}, DivMul};
    mul_h = {{DivMulW{1'b0}}, s1_ph_q} * {{ProdW{1'b0}}, DivMul};
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_box_q  <= clip_box;
      s2_full_q <= s1_full_q;
      s2_qw_q   <= mul_w[DivShift +: CfgW];
      s2_qh_q   <= mul_h[DivShift +: CfgW];
    end
  end

  // Stage 3: centered view bounds
  box_t            s3_box_q;
  logic            s3_full_q;
  view_t           view_d, s3_view_q;
  logic [CfgW-1:0] vw, vh, lw, th;

  always_comb begin
    vw = {s2_qw_q[CfgW-1:3], 3'b000};
    vh = {s2_qh_q[CfgW-1:1], 1'b0};
    lw = (sw_q - vw) >> 1;
    th = (sh_q - vh) >> 1;
    view_d.left   = $signed({2'b00, lw});
    view_d.top    = $signed({2'b00, th});
    view_d.right  = $signed({2'b00, lw}) + $signed({2'b00, vw}) - 15'sd1;
    view_d.bottom = $signed({2'b00, th}) + $signed({2'b00, vh}) - 15'sd1;
  end

  always_ff @(posedge clk_i) begin
    if (adv3) begin
      s3_box_q  <= s2_box_q;
      s3_full_q <= s2_full_q;
      s3_view_q <= view_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= fe_fire || (v1_q && !adv2);
      v2_q <= adv2 || (v2_q && !adv3);
      v3_q <= adv3 || (v3_q && !ld_b);
    end
  end

  // Strip cut into the output bundle
  strips_t strips;

  drtc_strip_cut u_strip_cut (
    .box_i    (s3_box_q),
    .view_i   (s3_view_q),
    .full_i   (s3_full_q),
    .strips_o (strips)
  );

  rect_t [MaxRects-1:0] rects_q;
  logic                 empty_q;

  always_ff @(posedge clk_i) begin
    if (ld_b) begin
      rects_q <= strips.rects;
      empty_q <= strips.empty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (ld_b) begin
      pend_q <= strips.pend;
    end else if (out_fire) begin
      pend_q <= pend_clr;
    end
  end

  // Output word: lowest pending strip first
  logic [SelW-1:0] sel;
  rect_t           out_rect;

  always_comb begin
    sel = SelW'(MaxRects - 1);
    for (int i = MaxRects - 1; i >= 0; i--) begin
      if (pend_q[i]) sel = SelW'(i);
    end
    out_rect = rects_q[sel];
  end

  assign m_axis_tvalid = (pend_q != '0);
  assign m_axis_tdata  = {4'b0000, out_rect.h, out_rect.w, out_rect.y, out_rect.x};
  assign m_axis_tuser  = empty_q;
  assign m_axis_tlast  = (pend_clr == '0);

  // Checks
  `ASSERT_IMP(a_empty_single, clk_i, rst_ni, empty_q && (pend_q != '0),
              pend_q == MaxRects'(1), "empty bundle holds more than one word")
  `ASSERT_IMP(a_stall_full, clk_i, rst_ni, !s_axis_tready,
              v1_q && v2_q && v3_q && (pend_q != '0), "input stalled with room")
  `ASSERT_NXT(a_frame_reset, clk_i, rst_ni, fe_fire && !fe_full,
              cur_q == BoxReset, "current box not reset after frame end")
  `ASSERT_NXT(a_bundle_out, clk_i, rst_ni, ld_b, m_axis_tvalid,
              "loaded bundle shows no output word")

endmodule
